// File: rtl/kuf_pkg.sv
// shared types and constants of the kruskal union-find engine
package kuf_pkg;

    localparam int unsigned ID_W     = 11;
    localparam int unsigned WEIGHT_W = 52;
    localparam int unsigned TOTAL_W  = 63;

    // edge queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // one classified edge as held in the queue
    typedef struct packed {
        logic                in_range;
        logic [ID_W-1:0]     node_a;
        logic [ID_W-1:0]     node_b;
        logic [WEIGHT_W-1:0] weight;
    } edge_entry_t;

    // head of the queue as seen by the back part
    typedef struct packed {
        logic        valid;
        edge_entry_t entry;
    } queue_head_t;

    // control from the back part to the front part
    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctrl_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND,
        ST_HALVE,
        ST_LINK
    } back_state_t;

endpackage

// File: rtl/kuf_edge_if.sv
// edge channel: valid/ready handshake carrying two node ids and a weight
interface kuf_edge_if;
    import kuf_pkg::*;

    logic                valid;
    logic                ready;
    logic [ID_W-1:0]     node_a;
    logic [ID_W-1:0]     node_b;
    logic [WEIGHT_W-1:0] weight;

    modport source (output valid, output node_a, output node_b, output weight, input ready);
    modport sink   (input valid, input node_a, input node_b, input weight, output ready);
endinterface

// File: rtl/kuf_result_if.sv
// result channel: valid/ready handshake carrying the join flags and the running total
interface kuf_result_if;
    import kuf_pkg::*;

    logic               valid;
    logic               ready;
    logic               joined;
    logic               to_plant;
    logic [TOTAL_W-1:0] total_cost;

    modport source (output valid, output joined, output to_plant, output total_cost,
                    input ready);
    modport sink   (input valid, input joined, input to_plant, input total_cost,
                    output ready);
endinterface

// File: rtl/kuf_parent_ram.sv
// parent table memory: one write port, one read port with registered read data
module kuf_parent_ram #(
    parameter int unsigned DEPTH = 2048,
    parameter int unsigned AW    = 11
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [AW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [AW-1:0] rd_data
);

    logic [AW-1:0] mem [DEPTH];
    logic [AW-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/kuf_front.sv
// front part: accepts edge words, checks node ids against the table size, queues them
module kuf_front #(
    parameter int unsigned NODE_COUNT = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    kuf_edge_if.sink    edges,
    input  kuf_pkg::back_ctrl_t  ctrl,
    output kuf_pkg::queue_head_t head
);
    import kuf_pkg::*;

    edge_entry_t         q_mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                push;
    logic                pop;
    logic                a_ok;
    logic                b_ok;
    edge_entry_t         new_entry;

    // classify incoming word
    always_comb
    begin
        a_ok = 32'(edges.node_a) < NODE_COUNT;
        b_ok = 32'(edges.node_b) < NODE_COUNT;
        new_entry.in_range = a_ok && b_ok;
        new_entry.node_a   = edges.node_a;
        new_entry.node_b   = edges.node_b;
        new_entry.weight   = edges.weight;
    end

    // handshake and pointer update
    assign edges.ready = !ctrl.clearing && (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push        = edges.valid && edges.ready;
    assign pop         = ctrl.pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= new_entry;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.entry = q_mem_reg[rd_ptr_reg];

endmodule

// File: rtl/kuf_back.sv
// back part: root walks with path halving, linking, saturating total and result register
module kuf_back #(
    parameter int unsigned NODE_COUNT = 2048,
    parameter int unsigned AW         = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  kuf_pkg::queue_head_t head,
    output kuf_pkg::back_ctrl_t  ctrl,
    output logic          ram_wr_en,
    output logic [AW-1:0] ram_wr_addr,
    output logic [AW-1:0] ram_wr_data,
    output logic          ram_rd_en,
    output logic [AW-1:0] ram_rd_addr,
    input  logic [AW-1:0] ram_rd_data,
    kuf_result_if.source  results
);
    import kuf_pkg::*;

    back_state_t          state_reg, state_next;
    logic [AW-1:0]        clr_addr_reg, clr_addr_next;
    logic [AW-1:0]        cur_reg, cur_next;
    logic [AW-1:0]        ra_reg, ra_next;
    logic [AW-1:0]        b_reg, b_next;
    logic                 phase_b_reg, phase_b_next;
    logic                 plant_reg, plant_next;
    logic [WEIGHT_W-1:0]  weight_reg, weight_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_joined_reg, out_joined_next;
    logic                 out_plant_reg, out_plant_next;
    logic [TOTAL_W:0]     sum;
    logic                 can_pop;
    logic                 roots_differ;

    assign sum          = {1'b0, total_reg} + {(TOTAL_W+1-WEIGHT_W)'(0), weight_reg};
    assign roots_differ = (ra_reg != cur_reg);
    assign can_pop      = head.valid && (!out_valid_reg || results.ready);

    // next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        cur_next        = cur_reg;
        ra_next         = ra_reg;
        b_next          = b_reg;
        phase_b_next    = phase_b_reg;
        plant_next      = plant_reg;
        weight_next     = weight_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_joined_next = out_joined_reg;
        out_plant_next  = out_plant_reg;
        ctrl.pop        = 1'b0;
        ctrl.clearing   = 1'b0;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = cur_reg;
        ram_wr_data     = ram_rd_data;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = ram_rd_data;

        case (state_reg)
            // sweep the table back to identity after reset
            ST_CLEAR:
            begin
                ctrl.clearing = 1'b1;
                ram_wr_en     = 1'b1;
                ram_wr_addr   = clr_addr_reg;
                ram_wr_data   = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(NODE_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            // take the next queued edge once the result slot is free
            ST_IDLE:
            begin
                if (can_pop)
                begin
                    ctrl.pop = 1'b1;
                    if (!head.entry.in_range)
                    begin
                        out_valid_next  = 1'b1;
                        out_joined_next = 1'b0;
                        out_plant_next  = 1'b0;
                    end
                    else
                    begin
                        ram_rd_en    = 1'b1;
                        ram_rd_addr  = AW'(head.entry.node_a);
                        cur_next     = AW'(head.entry.node_a);
                        b_next       = AW'(head.entry.node_b);
                        phase_b_next = 1'b0;
                        weight_next  = head.entry.weight;
                        plant_next   = (head.entry.node_a == '0) || (head.entry.node_b == '0);
                        state_next   = ST_FIND;
                    end
                end
            end

            // parent of cur is in the read register
            ST_FIND:
            begin
                if (ram_rd_data == cur_reg)
                begin
                    if (!phase_b_reg)
                    begin
                        ra_next      = cur_reg;
                        cur_next     = b_reg;
                        phase_b_next = 1'b1;
                        ram_rd_en    = 1'b1;
                        ram_rd_addr  = b_reg;
                    end
                    else
                    begin
                        state_next = ST_LINK;
                    end
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ram_rd_data;
                    state_next  = ST_HALVE;
                end
            end

            // grandparent is in the read register: halve and step up
            ST_HALVE:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = cur_reg;
                ram_wr_data = ram_rd_data;
                cur_next    = ram_rd_data;
                ram_rd_en   = 1'b1;
                ram_rd_addr = ram_rd_data;
                state_next  = ST_FIND;
            end

            // second root hangs under the first, total saturates
            ST_LINK:
            begin
                out_valid_next  = 1'b1;
                out_joined_next = roots_differ;
                out_plant_next  = roots_differ && plant_reg;
                if (roots_differ)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = cur_reg;
                    ram_wr_data = ra_reg;
                    total_next  = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            phase_b_reg   <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            phase_b_reg   <= phase_b_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        ra_reg         <= ra_next;
        b_reg          <= b_next;
        plant_reg      <= plant_next;
        weight_reg     <= weight_next;
        out_joined_reg <= out_joined_next;
        out_plant_reg  <= out_plant_next;
    end

    assign results.valid      = out_valid_reg;
    assign results.joined     = out_joined_reg;
    assign results.to_plant   = out_plant_reg;
    assign results.total_cost = total_reg;

endmodule

// File: rtl/kruskal_union_find_engine.sv
// Kruskal union-find engine: edge queue, root-walk back part and parent table
//
// Usage: edges arrive on the "edges" channel, one word per edge (node_a, node_b,
// weight), already sorted by weight. Each edge yields exactly one result word on
// the "results" channel: joined, to_plant and the saturating total of joined weights.
// A word moves when valid and ready are both high at a rising clock edge.
// Reset: rst_n clears the control state, then the parent table is swept back to
// identity, one entry a cycle; edges.ready stays low meanwhile.
// Order: each edge passes through the queue, then the back part walks from both
// nodes to their roots with path halving (each step is a read of the parent, a read
// of the grandparent and a write through the parent memory) and links them. An edge
// with an out-of-range node id skips the root walks and yields its result directly.
// Flow: one edge at a time in the back part, set by those memory round trips;
// a four-word queue keeps taking edges meanwhile.
// Stall: a result waits in the output register while results.ready is low; the back
// part holds the next edge until that register is taken, the queue fills, then
// edges.ready falls.
module kruskal_union_find_engine #(
    parameter int unsigned NODE_COUNT = 2048
) (
    input  logic       clk,
    input  logic       rst_n,
    kuf_edge_if.sink   edges,
    kuf_result_if.source results
);
    import kuf_pkg::*;

    localparam int unsigned AW = $clog2(NODE_COUNT);

    back_ctrl_t    ctrl;
    queue_head_t   head;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [AW-1:0] ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [AW-1:0] ram_rd_data;

    // accept and classify
    kuf_front #(
        .NODE_COUNT (NODE_COUNT)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .edges (edges),
        .ctrl  (ctrl),
        .head  (head)
    );

    // root walks and linking
    kuf_back #(
        .NODE_COUNT (NODE_COUNT),
        .AW         (AW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .ctrl        (ctrl),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .results     (results)
    );

    // parent table
    kuf_parent_ram #(
        .DEPTH (NODE_COUNT),
        .AW    (AW)
    ) u_parent_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

// File: dv/kuf_tb_pkg.sv
// scoreboard of the kruskal union-find engine: forest predictor and expected result words
package kuf_tb_pkg;
    import kuf_pkg::*;

    // one expected result word
    typedef struct packed {
        logic               joined;
        logic               to_plant;
        logic [TOTAL_W-1:0] total_cost;
    } result_word_t;

    class forest_scoreboard #(int unsigned NODES = 2048);
        bit [ID_W-1:0]    uplink [NODES];
        bit [TOTAL_W-1:0] joined_cost;
        result_word_t     expected_words [$];
        int unsigned      mismatches;

        function new();
            for (int unsigned i = 0; i < NODES; i++)
            begin
                uplink[i] = ID_W'(i);
            end
            joined_cost = '0;
            mismatches  = 0;
        endfunction

        // root walk with path halving, guarded against a broken table
        function bit [ID_W-1:0] find_root(input bit [ID_W-1:0] node);
            bit [ID_W-1:0] cur;
            int unsigned   steps;
            cur   = node;
            steps = 0;
            while (uplink[cur] != cur && steps < NODES)
            begin
                uplink[cur] = uplink[uplink[cur]];
                cur = uplink[cur];
                steps++;
            end
            return cur;
        endfunction

        // accepted edge word: update the forest and queue the result it causes
        function void note_edge(input bit [ID_W-1:0] a, input bit [ID_W-1:0] b,
                                input bit [WEIGHT_W-1:0] w);
            result_word_t  word;
            bit [ID_W-1:0] root_a;
            bit [ID_W-1:0] root_b;
            bit [TOTAL_W:0] sum;
            word = '0;
            if (a < NODES && b < NODES)
            begin
                root_a = find_root(a);
                root_b = find_root(b);
                if (root_a != root_b)
                begin
                    uplink[root_b] = root_a;
                    word.joined    = 1'b1;
                    word.to_plant  = (a == 0 || b == 0);
                    sum = {1'b0, joined_cost} + w;
                    if (sum > TOTAL_MAX)
                        joined_cost = TOTAL_MAX;
                    else
                        joined_cost = sum[TOTAL_W-1:0];
                end
            end
            word.total_cost = joined_cost;
            expected_words.insert(expected_words.size(), word);
        endfunction

        // accepted result word against the oldest expectation
        function void check_result(input logic joined, input logic to_plant,
                                   input logic [TOTAL_W-1:0] total_cost);
            result_word_t want;
            if (expected_words.size() == 0)
            begin
                $error("result word with no edge outstanding");
                mismatches++;
                return;
            end
            want = expected_words.pop_front();
            if (joined !== want.joined)
            begin
                $error("joined: expected %0d, got %0d", want.joined, joined);
                mismatches++;
            end
            if (to_plant !== want.to_plant)
            begin
                $error("to_plant: expected %0d, got %0d", want.to_plant, to_plant);
                mismatches++;
            end
            if (total_cost !== want.total_cost)
            begin
                $error("total_cost: expected %0d, got %0d", want.total_cost, total_cost);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_words.size();
        endfunction
    endclass

endpackage

// File: dv/tb_top.sv
// testbench top of the kruskal union-find engine: edge driver, result sink and checker
module tb_top;
    import kuf_pkg::*;
    import kuf_tb_pkg::*;

    localparam int unsigned NODES        = 2048;
    localparam int unsigned RANDOM_EDGES = 1330;
    localparam int unsigned LATE_CYCLES  = 64;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam logic [WEIGHT_W-1:0] WMAX = {WEIGHT_W{1'b1}};

    logic clk;
    logic rst_n;

    kuf_edge_if   edges();
    kuf_result_if results();

    kruskal_union_find_engine #(
        .NODE_COUNT(NODES)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .edges   (edges),
        .results (results)
    );

    forest_scoreboard #(NODES) forest;

    int unsigned cycle_count = 0;
    int unsigned hold_request = 0;
    int unsigned hold_left = 0;
    bit          feed_steady = 1'b0;
    bit          sink_steady = 1'b0;

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // word monitor: a taken result word is checked before a taken edge word is noted
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (results.valid === 1'b1 && results.ready === 1'b1)
            forest.check_result(results.joined, results.to_plant, results.total_cost);
        if (edges.valid === 1'b1 && edges.ready === 1'b1)
            forest.note_edge(edges.node_a, edges.node_b, edges.weight);
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result sink: random stalls, steady stretches and a long hold-off on request
    initial
    begin
        results.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                results.ready <= 1'b0;
                hold_left--;
            end
            else if (sink_steady)
                results.ready <= 1'b1;
            else
                results.ready <= ($urandom_range(0, 99) >= 25);
        end
    end

    // drop valid for the given number of cycles with junk on the payload
    task automatic pause_edges(input int unsigned cycles);
        edges.valid  <= 1'b0;
        edges.node_a <= ID_W'($urandom);
        edges.node_b <= ID_W'($urandom);
        edges.weight <= WEIGHT_W'({$urandom, $urandom});
        repeat (cycles) @(posedge clk);
    endtask

    // offer one edge word until taken, then maybe idle
    task automatic send_edge(input logic [ID_W-1:0] a, input logic [ID_W-1:0] b,
                             input logic [WEIGHT_W-1:0] w);
        edges.valid  <= 1'b1;
        edges.node_a <= a;
        edges.node_b <= b;
        edges.weight <= w;
        do
            @(posedge clk);
        while (edges.ready !== 1'b1);
        if (!feed_steady && hold_left == 0 && $urandom_range(0, 99) < 25)
            pause_edges($urandom_range(1, 4));
    endtask

    // hold the feed until every outstanding result has come back
    task automatic drain_results();
        edges.valid <= 1'b0;
        do
            @(posedge clk);
        while (forest.pending() != 0);
    endtask

    // random node id: plant, a small crowded pool, or anywhere
    function automatic logic [ID_W-1:0] pick_node(input int unsigned pool_hi);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        else if (r < 60)
            return ID_W'($urandom_range(0, pool_hi));
        else
            return ID_W'($urandom);
    endfunction

    initial
    begin
        logic [ID_W-1:0]     a;
        logic [ID_W-1:0]     b;
        logic [WEIGHT_W-1:0] w;
        logic [WEIGHT_W-1:0] ramp_w;
        int unsigned         pool_hi;

        forest       = new();
        rst_n        = 1'b0;
        edges.valid  = 1'b0;
        edges.node_a = '0;
        edges.node_b = '0;
        edges.weight = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: plant links, self loops, same component, weight extremes, chains
        send_edge(11'd0, 11'd2047, '0);
        send_edge(11'd2047, 11'd0, 52'd5);
        send_edge(11'd5, 11'd5, 52'd7);
        send_edge(11'd1, 11'd2, WMAX);
        send_edge(11'd2, 11'd1, WMAX);
        send_edge(11'd2047, 11'd1, 52'd100);
        send_edge(11'd2, 11'd0, 52'd200);
        send_edge(11'd10, 11'd11, 52'd300);
        send_edge(11'd11, 11'd12, 52'd300);
        send_edge(11'd12, 11'd13, 52'd301);
        send_edge(11'd13, 11'd14, 52'd302);
        send_edge(11'd14, 11'd10, 52'd303);
        send_edge(11'd10, 11'd0, WMAX);
        send_edge(11'd0, 11'd0, WMAX);
        send_edge(11'h555, 11'h2AA, 52'hA_AAAA_AAAA_AAAA);
        send_edge(11'h2AA, 11'h555, 52'h5_5555_5555_5555);
        send_edge(11'd2046, 11'd2045, 52'd1);
        drain_results();

        // random: mostly ascending weights over crowded pools, some noise weights
        ramp_w = '0;
        for (int unsigned n = 0; n < RANDOM_EDGES; n++)
        begin
            feed_steady = (n >= 300 && n < 600);
            sink_steady = (n >= 450 && n < 750);
            if (n == 900)
                hold_request = 400;
            if (n == 1100)
                drain_results();
            pool_hi = (n < 600) ? 63 : 511;
            a = pick_node(pool_hi);
            b = ($urandom_range(0, 99) < 5) ? a : pick_node(pool_hi);
            if ($urandom_range(0, 99) < 80)
            begin
                ramp_w = ramp_w + $urandom_range(0, 1 << $urandom_range(0, 24));
                w = ramp_w;
            end
            else
            begin
                w = WEIGHT_W'({$urandom, $urandom});
                if ($urandom_range(0, 1) == 0)
                    ramp_w = w;
            end
            send_edge(a, b, w);
        end
        feed_steady = 1'b0;
        sink_steady = 1'b0;

        // wind down: wait for every result, then watch for strays
        drain_results();
        repeat (LATE_CYCLES) @(posedge clk);
        if (forest.mismatches == 0 && forest.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
